>>> sv/bmc_pkg.sv
package bmc_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [15:0] CH_PERCENT   = 16'h0025;
    localparam logic [15:0] CH_LBRACE    = 16'h007B;
    localparam logic [15:0] CH_RBRACE    = 16'h007D;
    localparam logic [15:0] CH_LBRACKET  = 16'h005B;
    localparam logic [15:0] CH_RBRACKET  = 16'h005D;
    localparam logic [15:0] CH_BACKSLASH = 16'h005C;
    localparam logic [15:0] CH_NEWLINE   = 16'h000A;

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_EOD  = 1'b1
    } t_in_op;

    typedef enum logic [2:0] {
        CMD_PUSH_BRACE,
        CMD_POP_BRACE,
        CMD_PUSH_BRACKET,
        CMD_POP_BRACKET,
        CMD_EOD
    } t_cmd_op;

    localparam int CMD_OP_W = $bits(t_cmd_op);

    typedef enum logic [1:0] {
        ERR_UNMATCHED_BRACE = 2'd0,
        ERR_UNCLOSED_BRACE  = 2'd1,
        ERR_UNCLOSED_BRACKET = 2'd2,
        ERR_OVERFLOW        = 2'd3
    } t_err_kind;

    // Saturate a counter value to the 16-bit report field.
    function automatic logic [15:0] clip16(input logic [31:0] v);
        logic [15:0] res;
        res = (|v[31:16]) ? 16'hFFFF : v[15:0];
        return res;
    endfunction

endpackage

>>> sv/bmc_ram.sv
module bmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bmc_fifo.sv
module bmc_fifo #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

endmodule

>>> sv/bmc_front.sv
module bmc_front #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_op,
    input  logic [15:0]            i_char_code,
    input  logic                   i_full,
    output logic                   o_push,
    output bmc_pkg::t_cmd_op       o_cmd_op,
    output logic [LINE_BITS-1:0]   o_line,
    output logic [COLUMN_BITS-1:0] o_col
);

    import bmc_pkg::*;

    logic [LINE_BITS-1:0]   r_line;
    logic [COLUMN_BITS-1:0] r_col;
    logic                   r_comment;
    logic                   r_bslash;
    logic [LINE_BITS-1:0]   n_line;
    logic [COLUMN_BITS-1:0] n_col;
    logic                   n_comment;
    logic                   n_bslash;
    logic                   accept;
    logic                   has_cmd;
    t_cmd_op                cmd_op;

    assign accept = i_valid && !i_full;

    always_comb begin
        n_line    = r_line;
        n_col     = r_col;
        n_comment = r_comment;
        n_bslash  = r_bslash;
        has_cmd   = 1'b0;
        cmd_op    = CMD_EOD;
        if (i_op == OP_EOD) begin
            n_line    = '0;
            n_col     = '0;
            n_comment = 1'b0;
            n_bslash  = 1'b0;
            has_cmd   = 1'b1;
        end else if (i_char_code == CH_NEWLINE) begin
            n_line    = (r_line != '1) ? r_line + 1'b1 : r_line;
            n_col     = '0;
            n_comment = 1'b0;
            n_bslash  = 1'b0;
        end else begin
            if (!r_comment) begin
                n_bslash = (i_char_code == CH_BACKSLASH);
                // escaped characters only feed the backslash tracking
                if (!r_bslash) begin
                    if (i_char_code == CH_PERCENT) begin
                        n_comment = 1'b1;
                    end else if (i_char_code == CH_LBRACE) begin
                        has_cmd = 1'b1;
                        cmd_op  = CMD_PUSH_BRACE;
                    end else if (i_char_code == CH_RBRACE) begin
                        has_cmd = 1'b1;
                        cmd_op  = CMD_POP_BRACE;
                    end else if (i_char_code == CH_LBRACKET) begin
                        has_cmd = 1'b1;
                        cmd_op  = CMD_PUSH_BRACKET;
                    end else if (i_char_code == CH_RBRACKET) begin
                        has_cmd = 1'b1;
                        cmd_op  = CMD_POP_BRACKET;
                    end
                end
            end
            n_col = (r_col != '1) ? r_col + 1'b1 : r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line    <= '0;
            r_col     <= '0;
            r_comment <= 1'b0;
            r_bslash  <= 1'b0;
        end else if (accept) begin
            r_line    <= n_line;
            r_col     <= n_col;
            r_comment <= n_comment;
            r_bslash  <= n_bslash;
        end
    end

    assign o_stall  = i_full;
    assign o_push   = accept && has_cmd;
    assign o_cmd_op = cmd_op;
    assign o_line   = r_line;
    assign o_col    = r_col;

endmodule

>>> sv/bmc_back.sv
module bmc_back #(
    parameter int STACK_DEPTH = 32,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  bmc_pkg::t_cmd_op       i_cmd_op,
    input  logic [LINE_BITS-1:0]   i_line,
    input  logic [COLUMN_BITS-1:0] i_col,
    output logic                   o_cmd_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_error_kind,
    output logic [15:0]            o_line_number,
    output logic [15:0]            o_column_number,
    output logic                   o_last_of_run
);

    import bmc_pkg::*;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int POS_W   = LINE_BITS + COLUMN_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [DEPTH_W-1:0] r_brace_depth;
    logic [DEPTH_W-1:0] r_bracket_depth;
    logic               r_kind_bracket;
    logic               r_last;
    logic               r_o_valid;
    t_err_kind          r_o_kind;
    logic [15:0]        r_o_line;
    logic [15:0]        r_o_col;
    logic               r_o_last;

    logic               out_free;
    logic               take;
    logic               brace_full;
    logic               bracket_full;
    logic               brace_we;
    logic               bracket_we;
    logic               rd_brace;
    logic               rd_bracket;
    logic [DEPTH_W-1:0] brace_dec;
    logic [DEPTH_W-1:0] bracket_dec;
    logic [POS_W-1:0]   wr_pos;
    logic [POS_W-1:0]   brace_rdata;
    logic [POS_W-1:0]   bracket_rdata;
    logic [POS_W-1:0]   pop_pos;

    always_comb begin
        out_free     = !r_o_valid || !i_stall;
        take         = (r_state == S_IDLE) && i_cmd_valid && out_free;
        brace_full   = (r_brace_depth == DEPTH_W'(STACK_DEPTH));
        bracket_full = (r_bracket_depth == DEPTH_W'(STACK_DEPTH));
        brace_we     = take && (i_cmd_op == CMD_PUSH_BRACE) && !brace_full;
        bracket_we   = take && (i_cmd_op == CMD_PUSH_BRACKET) && !bracket_full;
        rd_brace     = (r_state == S_RD) && (r_brace_depth != '0);
        rd_bracket   = (r_state == S_RD) && (r_brace_depth == '0)
                       && (r_bracket_depth != '0);
        brace_dec    = r_brace_depth - 1'b1;
        bracket_dec  = r_bracket_depth - 1'b1;
        wr_pos       = {i_line, i_col};
        pop_pos      = r_kind_bracket ? bracket_rdata : brace_rdata;
    end

    bmc_ram #(
        .WIDTH (POS_W),
        .DEPTH (STACK_DEPTH)
    ) u_brace_ram (
        .i_clk   (i_clk),
        .i_we    (brace_we),
        .i_waddr (r_brace_depth[IDX_W-1:0]),
        .i_wdata (wr_pos),
        .i_re    (rd_brace),
        .i_raddr (brace_dec[IDX_W-1:0]),
        .o_rdata (brace_rdata)
    );

    bmc_ram #(
        .WIDTH (POS_W),
        .DEPTH (STACK_DEPTH)
    ) u_bracket_ram (
        .i_clk   (i_clk),
        .i_we    (bracket_we),
        .i_waddr (r_bracket_depth[IDX_W-1:0]),
        .i_wdata (wr_pos),
        .i_re    (rd_bracket),
        .i_raddr (bracket_dec[IDX_W-1:0]),
        .o_rdata (bracket_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_brace_depth   <= '0;
            r_bracket_depth <= '0;
            r_kind_bracket  <= 1'b0;
            r_last          <= 1'b0;
            r_o_valid       <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        case (i_cmd_op)
                            CMD_PUSH_BRACE, CMD_PUSH_BRACKET: begin
                                if ((i_cmd_op == CMD_PUSH_BRACE) ? brace_full
                                                                 : bracket_full) begin
                                    r_o_valid <= 1'b1;
                                    r_o_kind  <= ERR_OVERFLOW;
                                    r_o_line  <= clip16(32'(i_line));
                                    r_o_col   <= clip16(32'(i_col));
                                    r_o_last  <= 1'b1;
                                end else if (i_cmd_op == CMD_PUSH_BRACE) begin
                                    r_brace_depth <= r_brace_depth + 1'b1;
                                end else begin
                                    r_bracket_depth <= r_bracket_depth + 1'b1;
                                end
                            end
                            CMD_POP_BRACE: begin
                                if (r_brace_depth == '0) begin
                                    r_o_valid <= 1'b1;
                                    r_o_kind  <= ERR_UNMATCHED_BRACE;
                                    r_o_line  <= clip16(32'(i_line));
                                    r_o_col   <= clip16(32'(i_col));
                                    r_o_last  <= 1'b1;
                                end else begin
                                    r_brace_depth <= brace_dec;
                                end
                            end
                            CMD_POP_BRACKET: begin
                                if (r_bracket_depth != '0) begin
                                    r_bracket_depth <= bracket_dec;
                                end
                            end
                            CMD_EOD: begin
                                r_state <= S_RD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    // braces drain first, then brackets, both top down
                    if (rd_brace) begin
                        r_brace_depth  <= brace_dec;
                        r_kind_bracket <= 1'b0;
                        r_last         <= (brace_dec == '0) && (r_bracket_depth == '0);
                        r_state        <= S_EMIT;
                    end else if (rd_bracket) begin
                        r_bracket_depth <= bracket_dec;
                        r_kind_bracket  <= 1'b1;
                        r_last          <= (bracket_dec == '0);
                        r_state         <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= r_kind_bracket ? ERR_UNCLOSED_BRACKET
                                                    : ERR_UNCLOSED_BRACE;
                        r_o_line  <= clip16(32'(pop_pos[POS_W-1:COLUMN_BITS]));
                        r_o_col   <= clip16(32'(pop_pos[COLUMN_BITS-1:0]));
                        r_o_last  <= r_last;
                        r_state   <= S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd_pop       = take;
    assign o_valid         = r_o_valid;
    assign o_error_kind    = r_o_kind;
    assign o_line_number   = r_o_line;
    assign o_column_number = r_o_col;
    assign o_last_of_run   = r_o_last;

endmodule

>>> sv/brace_bracket_match_checker.sv
// An error from a character passes the command queue, then the output register.
// Throughput: one character per cycle while the command queue has room; the
// queue absorbs output stalls until full. End of document: each unclosed brace
// or bracket is read back from its stack RAM, then emitted; input keeps queueing.
// Reset (i_rst_n low, synchronous): counters, stacks and queue empty, output idle.
module brace_bracket_match_checker #(
    parameter int STACK_DEPTH = bmc_pkg::STACK_DEPTH_DEF,
    parameter int LINE_BITS   = bmc_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = bmc_pkg::COLUMN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [15:0] i_char_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_error_kind,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column_number,
    output logic        o_last_of_run
);

    import bmc_pkg::*;

    localparam int CMD_W = CMD_OP_W + LINE_BITS + COLUMN_BITS;

    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_valid;
    logic [CMD_W-1:0]       q_wdata;
    logic [CMD_W-1:0]       q_rdata;
    t_cmd_op                f_op;
    logic [LINE_BITS-1:0]   f_line;
    logic [COLUMN_BITS-1:0] f_col;

    bmc_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_cmd_op    (f_op),
        .o_line      (f_line),
        .o_col       (f_col)
    );

    assign q_wdata = {f_op, f_line, f_col};

    bmc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    bmc_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd_op        (t_cmd_op'(q_rdata[CMD_W-1:LINE_BITS+COLUMN_BITS])),
        .i_line          (q_rdata[LINE_BITS+COLUMN_BITS-1:COLUMN_BITS]),
        .i_col           (q_rdata[COLUMN_BITS-1:0]),
        .o_cmd_pop       (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_error_kind    (o_error_kind),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bmc_pkg::*;

    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER = 200;
    localparam int unsigned RANDOM_ITEMS = 300;

    typedef struct {
        t_in_op      op;
        logic [15:0] code;
        int unsigned gap;
    } t_text_item;

    typedef struct packed {
        logic [LINE_BITS_DEF-1:0]   line;
        logic [COLUMN_BITS_DEF-1:0] col;
    } t_spot;

    typedef struct packed {
        t_err_kind   kind;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } t_error_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_op = 1'b0;
    logic [15:0] i_char_code = 16'h0000;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_error_kind;
    logic [15:0] o_line_number;
    logic [15:0] o_column_number;
    logic        o_last_of_run;

    t_text_item    text_items[$];
    t_error_report expected_errors[$];

    // scanner state mirrored from the block
    logic [LINE_BITS_DEF-1:0]   cur_line;
    logic [COLUMN_BITS_DEF-1:0] cur_col;
    bit                         in_comment;
    bit                         after_backslash;
    t_spot                      brace_stack[STACK_DEPTH_DEF];
    t_spot                      bracket_stack[STACK_DEPTH_DEF];
    int unsigned                brace_fill;
    int unsigned                bracket_fill;

    int unsigned chars_sent;
    int unsigned fail_count;
    int unsigned send_quiet;
    int unsigned recv_quiet;
    int unsigned gap_left;
    int unsigned out_wait;
    int unsigned hold_left;
    bit          hold_done;

    brace_bracket_match_checker u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_char_code     (i_char_code),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_error_kind    (o_error_kind),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_scanner();
        cur_line = '0;
        cur_col = '0;
        in_comment = 1'b0;
        after_backslash = 1'b0;
        brace_fill = 0;
        bracket_fill = 0;
    endfunction

    function automatic void add_error(input t_err_kind kind, input t_spot where);
        logic [31:0]   wide_line;
        logic [31:0]   wide_col;
        t_error_report rep;
        wide_line = 32'(where.line);
        wide_col = 32'(where.col);
        rep.kind = kind;
        rep.line = (wide_line > 32'hFFFF) ? 16'hFFFF : wide_line[15:0];
        rep.col = (wide_col > 32'hFFFF) ? 16'hFFFF : wide_col[15:0];
        rep.last = 1'b0;
        expected_errors.push_back(rep);
    endfunction

    // Advance the scanner by one accepted transfer and queue the errors it reports.
    function automatic void scan_item(input t_in_op op, input logic [15:0] code);
        int    first;
        bit    escaped;
        t_spot here;
        first = expected_errors.size();
        here.line = cur_line;
        here.col = cur_col;
        if (op == OP_EOD) begin
            while (brace_fill > 0) begin
                brace_fill--;
                add_error(ERR_UNCLOSED_BRACE, brace_stack[brace_fill]);
            end
            while (bracket_fill > 0) begin
                bracket_fill--;
                add_error(ERR_UNCLOSED_BRACKET, bracket_stack[bracket_fill]);
            end
            clear_scanner();
        end else if (code == CH_NEWLINE) begin
            if (cur_line != '1)
                cur_line++;
            cur_col = '0;
            in_comment = 1'b0;
            after_backslash = 1'b0;
        end else begin
            if (!in_comment) begin
                escaped = after_backslash;
                // an escaped backslash still escapes the next character
                after_backslash = (code == CH_BACKSLASH);
                if (!escaped) begin
                    case (code)
                        CH_PERCENT: in_comment = 1'b1;
                        CH_LBRACE: begin
                            if (brace_fill == STACK_DEPTH_DEF) begin
                                add_error(ERR_OVERFLOW, here);
                            end else begin
                                brace_stack[brace_fill] = here;
                                brace_fill++;
                            end
                        end
                        CH_RBRACE: begin
                            if (brace_fill == 0)
                                add_error(ERR_UNMATCHED_BRACE, here);
                            else
                                brace_fill--;
                        end
                        CH_LBRACKET: begin
                            if (bracket_fill == STACK_DEPTH_DEF) begin
                                add_error(ERR_OVERFLOW, here);
                            end else begin
                                bracket_stack[bracket_fill] = here;
                                bracket_fill++;
                            end
                        end
                        CH_RBRACKET: begin
                            if (bracket_fill > 0)
                                bracket_fill--;
                        end
                        default: ;
                    endcase
                end
            end
            if (cur_col != '1)
                cur_col++;
        end
        if (expected_errors.size() > first)
            expected_errors[$].last = 1'b1;
    endfunction

    // Wait draw with occasional runs of back-to-back transfers.
    function automatic int unsigned pick_wait(inout int unsigned quiet);
        if (quiet != 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic void queue_item(input t_in_op op, input logic [15:0] code,
                                       input bit burst = 1'b0);
        t_text_item item;
        item.op = op;
        item.code = code;
        item.gap = burst ? 0 : pick_wait(send_quiet);
        text_items.push_back(item);
    endfunction

    function automatic logic [15:0] random_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 22) return CH_LBRACE;
        if (r < 34) return CH_RBRACE;
        if (r < 50) return CH_LBRACKET;
        if (r < 60) return CH_RBRACKET;
        if (r < 66) return CH_BACKSLASH;
        if (r < 71) return CH_PERCENT;
        if (r < 79) return CH_NEWLINE;
        if (r < 88) return 16'($urandom);
        return 16'($urandom_range(32, 126));
    endfunction

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // sender
    always @(posedge i_clk) begin
        t_text_item item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_op <= OP_CHAR;
            i_char_code <= 16'h0000;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                scan_item(t_in_op'(i_op), i_char_code);
                chars_sent++;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left != 0) begin
                    i_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (text_items.size() != 0) begin
                    item = text_items.pop_front();
                    i_valid <= 1'b1;
                    i_op <= item.op;
                    i_char_code <= item.code;
                    gap_left <= item.gap;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && chars_sent >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        int unsigned   wait_next;
        t_error_report want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            out_wait <= 0;
        end else begin
            wait_next = out_wait;
            if (o_valid && !i_stall) begin
                if (expected_errors.size() == 0) begin
                    report_failure($sformatf(
                        "unexpected error transfer: kind %0d line %0d col %0d last %0d",
                        o_error_kind, o_line_number, o_column_number, o_last_of_run));
                end else begin
                    want = expected_errors.pop_front();
                    if (o_error_kind !== want.kind || o_line_number !== want.line ||
                        o_column_number !== want.col || o_last_of_run !== want.last) begin
                        report_failure($sformatf(
                            "mismatch: expected kind %0d line %0d col %0d last %0d, got %0d %0d %0d %0d",
                            want.kind, want.line, want.col, want.last,
                            o_error_kind, o_line_number, o_column_number, o_last_of_run));
                    end
                end
                wait_next = pick_wait(recv_quiet);
            end else if (wait_next != 0) begin
                wait_next--;
            end
            out_wait <= wait_next;
            i_stall <= (wait_next != 0) || (hold_left != 0);
        end
    end

    // watchdog on cycles with no transfer on either side
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("brace_bracket_match_checker test failed");
        $finish;
    end

    initial begin
        int unsigned start;
        int unsigned len;
        int unsigned shape;
        clear_scanner();
        chars_sent = 0;
        fail_count = 0;
        send_quiet = 0;
        recv_quiet = 0;

        // directed: matching, escapes, comments, odd codes, empty end
        queue_item(OP_CHAR, CH_LBRACE);
        queue_item(OP_CHAR, CH_RBRACE);
        queue_item(OP_CHAR, CH_RBRACE);
        queue_item(OP_CHAR, CH_LBRACKET);
        queue_item(OP_CHAR, CH_RBRACKET);
        queue_item(OP_CHAR, CH_RBRACKET);
        queue_item(OP_CHAR, CH_BACKSLASH);
        queue_item(OP_CHAR, CH_LBRACE);
        queue_item(OP_CHAR, CH_BACKSLASH);
        queue_item(OP_CHAR, CH_PERCENT);
        queue_item(OP_CHAR, CH_LBRACE);
        queue_item(OP_CHAR, CH_BACKSLASH);
        queue_item(OP_CHAR, CH_BACKSLASH);
        queue_item(OP_CHAR, CH_LBRACE);
        queue_item(OP_CHAR, CH_LBRACKET);
        queue_item(OP_CHAR, CH_PERCENT);
        queue_item(OP_CHAR, CH_LBRACE);
        queue_item(OP_CHAR, CH_BACKSLASH);
        queue_item(OP_CHAR, CH_NEWLINE);
        queue_item(OP_CHAR, CH_LBRACE);
        queue_item(OP_CHAR, 16'hFFFF);
        queue_item(OP_CHAR, 16'h0000);
        queue_item(OP_CHAR, 16'h017B);
        queue_item(OP_CHAR, CH_BACKSLASH);
        queue_item(OP_CHAR, CH_NEWLINE);
        queue_item(OP_CHAR, CH_LBRACE);
        queue_item(OP_EOD, CH_LBRACE);
        queue_item(OP_EOD, 16'hFFFF);
        queue_item(OP_CHAR, CH_RBRACE);
        queue_item(OP_EOD, 16'h0000);

        // full stacks: overflow on both, then the largest flush
        repeat (STACK_DEPTH_DEF + 2) queue_item(OP_CHAR, CH_LBRACE);
        queue_item(OP_EOD, 16'($urandom));
        repeat (STACK_DEPTH_DEF + 1) queue_item(OP_CHAR, CH_LBRACE);
        repeat (STACK_DEPTH_DEF + 1) queue_item(OP_CHAR, CH_LBRACKET);
        queue_item(OP_EOD, 16'($urandom));

        // random documents: mostly random characters, some deep nesting and noise
        start = text_items.size();
        while (text_items.size() - start < RANDOM_ITEMS) begin
            shape = $urandom_range(0, 9);
            if (shape < 7) begin
                len = $urandom_range(1, 40);
                repeat (len) queue_item(OP_CHAR, random_char());
            end else if (shape < 8) begin
                len = $urandom_range(28, 45);
                repeat (len) begin
                    if ($urandom_range(0, 5) != 0)
                        queue_item(OP_CHAR, $urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET);
                    else
                        queue_item(OP_CHAR, random_char());
                end
            end else begin
                len = $urandom_range(1, 30);
                repeat (len) begin
                    if ($urandom_range(0, 2) == 0)
                        queue_item(OP_CHAR, $urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
                    else
                        queue_item(OP_CHAR, 16'($urandom));
                end
            end
            // now and then two documents run together
            if ($urandom_range(0, 5) != 0)
                queue_item(OP_EOD, 16'($urandom));
        end
        queue_item(OP_EOD, 16'($urandom));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_items.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_errors.size() != 0)
            @(posedge i_clk);
        // room for a late flush or stray result
        repeat (300) @(posedge i_clk);

        if (fail_count == 0)
            $display("brace_bracket_match_checker test passed");
        else
            $display("brace_bracket_match_checker test failed");
        $finish;
    end

endmodule
